FILE: rtl/adbh_pkg.sv
package adbh_pkg;

	// Size of the connection table.
	localparam int SLOTS  = 8;
	localparam int SLOT_W = $clog2(SLOTS);
	localparam int CNT_W  = SLOT_W + 1;

	// Input opcodes.
	localparam logic [2:0] OP_TICK   = 3'd0;
	localparam logic [2:0] OP_HEADER = 3'd1;
	localparam logic [2:0] OP_ATTACH = 3'd2;
	localparam logic [2:0] OP_DETACH = 3'd3;
	localparam logic [2:0] OP_WRITE  = 3'd4;

	// Link command words.
	localparam logic [31:0] CMD_CNXN = 32'h4e584e43;
	localparam logic [31:0] CMD_OPEN = 32'h4e45504f;
	localparam logic [31:0] CMD_OKAY = 32'h59414b4f;
	localparam logic [31:0] CMD_CLSE = 32'h45534c43;
	localparam logic [31:0] CMD_WRTE = 32'h45545257;

	// Fixed words of the outgoing connect header, the event length cap and the header size.
	localparam logic [31:0] CNXN_VERSION = 32'h01000000;
	localparam logic [31:0] CNXN_MAXDATA = 32'd4096;
	localparam logic [31:0] CNXN_ID_LEN  = 32'd17;
	localparam logic [31:0] EVT_LEN_CAP  = 32'd256;
	localparam logic [6:0]  HDR_BYTES    = 7'd24;

	// Slot status codes.
	localparam logic [2:0] SLOT_UNUSED  = 3'd0;
	localparam logic [2:0] SLOT_CLOSED  = 3'd1;
	localparam logic [2:0] SLOT_OPENING = 3'd2;
	localparam logic [2:0] SLOT_OPEN    = 3'd3;
	localparam logic [2:0] SLOT_WRITING = 3'd4;

	// Result kinds.
	localparam logic [1:0] KIND_HDR    = 2'd0;
	localparam logic [1:0] KIND_EVENT  = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	// Event codes.
	localparam logic [2:0] EVT_CONNECT   = 3'd0;
	localparam logic [2:0] EVT_OPENED    = 3'd1;
	localparam logic [2:0] EVT_OPEN_FAIL = 3'd2;
	localparam logic [2:0] EVT_CLOSED    = 3'd3;
	localparam logic [2:0] EVT_DATA      = 3'd4;

	// Write request status codes.
	localparam logic [1:0] WST_ACCEPTED = 2'd0;
	localparam logic [1:0] WST_NO_LINK  = 2'd1;
	localparam logic [1:0] WST_NOT_OPEN = 2'd2;

	// Result selection from controller to datapath.
	localparam logic [3:0] RES_HDR_CNXN     = 4'd0;
	localparam logic [3:0] RES_HDR_OPEN     = 4'd1;
	localparam logic [3:0] RES_HDR_OKAY     = 4'd2;
	localparam logic [3:0] RES_HDR_WRTE     = 4'd3;
	localparam logic [3:0] RES_EVT_CONNECT  = 4'd4;
	localparam logic [3:0] RES_EVT_OPEN     = 4'd5;
	localparam logic [3:0] RES_EVT_CLOSE    = 4'd6;
	localparam logic [3:0] RES_EVT_DATA     = 4'd7;
	localparam logic [3:0] RES_ST_ACCEPTED  = 4'd8;
	localparam logic [3:0] RES_ST_NO_LINK   = 4'd9;
	localparam logic [3:0] RES_ST_NOT_OPEN  = 4'd10;

	// Register map.
	localparam logic REG_SLOTS_IN_USE   = 1'b0;
	localparam logic REG_RECONNECT_MASK = 1'b1;

	typedef struct packed {
		logic [3:0] slots_in_use;
		logic [7:0] reconnect_mask;
	} adbh_cfg_t;

	// Commands from the controller.
	typedef struct packed {
		logic       load;
		logic       emit;
		logic [3:0] sel;
		logic       last;
		logic       clear_sent;
		logic       set_present;
		logic       detach;
		logic       okay_wr;
	} adbh_cmd_t;

	// Status towards the controller.
	typedef struct packed {
		logic [2:0] op;
		logic       present;
		logic       link;
		logic       sent;
		logic       hdr_ok;
		logic       is_cnxn;
		logic       is_okay;
		logic       is_clse;
		logic       is_wrte;
		logic       id_ok;
		logic [2:0] cur_status;
		logic       dl_nz;
		logic       ws_ok;
		logic       mask_any;
		logic       mask_more;
		logic       out_free;
	} adbh_sts_t;

endpackage

FILE: rtl/adbh_datapath.sv
module adbh_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  adbh_pkg::adbh_cfg_t      cfg,
	input  adbh_pkg::adbh_cmd_t      cmd,
	output adbh_pkg::adbh_sts_t      sts,
	input  logic [2:0]               opcode,
	input  logic [31:0]              command,
	input  logic [31:0]              arg_first,
	input  logic [31:0]              arg_second,
	input  logic [31:0]              magic,
	input  logic [31:0]              payload_len,
	input  logic [6:0]               header_bytes,
	input  logic [2:0]               slot,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               kind,
	output logic [31:0]              out_command,
	output logic [31:0]              out_arg_first,
	output logic [31:0]              out_arg_second,
	output logic [31:0]              out_length,
	output logic [31:0]              out_magic,
	output logic [2:0]               event_code,
	output logic [2:0]               event_slot,
	output logic [1:0]               write_status,
	output logic                     last
);

	// Latched input item.
	logic [2:0]  op_q;
	logic [31:0] command_q;
	logic [31:0] a0_q;
	logic [31:0] a1_q;
	logic [31:0] magic_q;
	logic [31:0] dl_q;
	logic [6:0]  hb_q;
	logic [2:0]  ws_q;

	// Connection table and link flags.
	logic [2:0]  slot_status_q [adbh_pkg::SLOTS];
	logic [31:0] slot_remote_q [adbh_pkg::SLOTS];
	logic        present_q;
	logic        link_q;
	logic        sent_q;
	logic [adbh_pkg::SLOTS-1:0] walk_mask_q;

	// Output register.
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [31:0] out_command_q;
	logic [31:0] out_arg_first_q;
	logic [31:0] out_arg_second_q;
	logic [31:0] out_length_q;
	logic [31:0] out_magic_q;
	logic [2:0]  event_code_q;
	logic [2:0]  event_slot_q;
	logic [1:0]  write_status_q;
	logic        last_q;

	logic [adbh_pkg::CNT_W-1:0]  active_n;
	logic [adbh_pkg::SLOTS-1:0]  tick_mask;
	logic [adbh_pkg::SLOTS-1:0]  det_mask;
	logic [adbh_pkg::SLOT_W-1:0] walk_top;
	logic [adbh_pkg::SLOT_W-1:0] cur_slot;
	logic [2:0]                  cur_status;
	logic                        out_free;

	logic [1:0]  res_kind;
	logic [31:0] res_command;
	logic [31:0] res_arg_first;
	logic [31:0] res_arg_second;
	logic [31:0] res_length;
	logic [2:0]  res_code;
	logic [1:0]  res_status;

	// Active slot count, clipped to the table size.
	assign active_n = (cfg.slots_in_use > 4'(adbh_pkg::SLOTS)) ?
		adbh_pkg::CNT_W'(adbh_pkg::SLOTS) : adbh_pkg::CNT_W'(cfg.slots_in_use);

	// Slots that a tick or a detach will visit, one compare per slot.
	always_comb begin
		for (int i = 0; i < adbh_pkg::SLOTS; i++) begin
			tick_mask[i] = (adbh_pkg::CNT_W'(i) < active_n) &&
				(slot_status_q[i] == adbh_pkg::SLOT_CLOSED);
			det_mask[i] = (adbh_pkg::CNT_W'(i) < active_n) &&
				(slot_status_q[i] != adbh_pkg::SLOT_UNUSED) &&
				(slot_status_q[i] != adbh_pkg::SLOT_CLOSED);
		end
	end

	// Highest pending slot of the walk.
	always_comb begin
		walk_top = '0;
		for (int i = 0; i < adbh_pkg::SLOTS; i++) begin
			if (walk_mask_q[i]) begin
				walk_top = adbh_pkg::SLOT_W'(i);
			end
		end
	end

	// The slot that the current item concerns.
	always_comb begin
		case (op_q)
			adbh_pkg::OP_HEADER: cur_slot = a1_q[adbh_pkg::SLOT_W-1:0] - adbh_pkg::SLOT_W'(1);
			adbh_pkg::OP_WRITE:  cur_slot = ws_q;
			default:             cur_slot = walk_top;
		endcase
	end

	assign cur_status = slot_status_q[cur_slot];
	assign out_free   = !out_valid_q || out_ready;

	// Status towards the controller.
	always_comb begin
		sts.op         = op_q;
		sts.present    = present_q;
		sts.link       = link_q;
		sts.sent       = sent_q;
		sts.hdr_ok     = (hb_q == adbh_pkg::HDR_BYTES) && (magic_q == ~command_q);
		sts.is_cnxn    = (command_q == adbh_pkg::CMD_CNXN);
		sts.is_okay    = (command_q == adbh_pkg::CMD_OKAY);
		sts.is_clse    = (command_q == adbh_pkg::CMD_CLSE);
		sts.is_wrte    = (command_q == adbh_pkg::CMD_WRTE);
		sts.id_ok      = (a1_q != 32'd0) && (a1_q <= 32'(active_n)) &&
			(cur_status != adbh_pkg::SLOT_UNUSED);
		sts.cur_status = cur_status;
		sts.dl_nz      = (dl_q != 32'd0);
		sts.ws_ok      = (adbh_pkg::CNT_W'(ws_q) < active_n) &&
			(cur_status == adbh_pkg::SLOT_OPEN);
		sts.mask_any   = |walk_mask_q;
		sts.mask_more  = |(walk_mask_q & ~(adbh_pkg::SLOTS'(1) << walk_top));
		sts.out_free   = out_free;
	end

	// Fields of the selected result.
	always_comb begin
		res_kind       = adbh_pkg::KIND_EVENT;
		res_command    = 32'd0;
		res_arg_first  = 32'd0;
		res_arg_second = 32'd0;
		res_length     = 32'd0;
		res_code       = 3'd0;
		res_status     = 2'd0;
		unique case (cmd.sel)
			adbh_pkg::RES_HDR_CNXN: begin
				res_kind       = adbh_pkg::KIND_HDR;
				res_command    = adbh_pkg::CMD_CNXN;
				res_arg_first  = adbh_pkg::CNXN_VERSION;
				res_arg_second = adbh_pkg::CNXN_MAXDATA;
				res_length     = adbh_pkg::CNXN_ID_LEN;
			end
			adbh_pkg::RES_HDR_OPEN: begin
				res_kind      = adbh_pkg::KIND_HDR;
				res_command   = adbh_pkg::CMD_OPEN;
				res_arg_first = 32'(cur_slot) + 32'd1;
			end
			adbh_pkg::RES_HDR_OKAY: begin
				res_kind       = adbh_pkg::KIND_HDR;
				res_command    = adbh_pkg::CMD_OKAY;
				res_arg_first  = a1_q;
				res_arg_second = a0_q;
			end
			adbh_pkg::RES_HDR_WRTE: begin
				res_kind       = adbh_pkg::KIND_HDR;
				res_command    = adbh_pkg::CMD_WRTE;
				res_arg_first  = 32'(cur_slot) + 32'd1;
				res_arg_second = slot_remote_q[cur_slot];
				res_length     = dl_q;
			end
			adbh_pkg::RES_EVT_CONNECT: begin
				res_code   = adbh_pkg::EVT_CONNECT;
				res_length = (dl_q < adbh_pkg::EVT_LEN_CAP) ? dl_q : adbh_pkg::EVT_LEN_CAP;
			end
			adbh_pkg::RES_EVT_OPEN: begin
				res_code = adbh_pkg::EVT_OPENED;
			end
			adbh_pkg::RES_EVT_CLOSE: begin
				res_code = (cur_status == adbh_pkg::SLOT_OPENING) ?
					adbh_pkg::EVT_OPEN_FAIL : adbh_pkg::EVT_CLOSED;
			end
			adbh_pkg::RES_EVT_DATA: begin
				res_code   = adbh_pkg::EVT_DATA;
				res_length = dl_q;
			end
			adbh_pkg::RES_ST_ACCEPTED: begin
				res_kind   = adbh_pkg::KIND_STATUS;
				res_status = adbh_pkg::WST_ACCEPTED;
			end
			adbh_pkg::RES_ST_NO_LINK: begin
				res_kind   = adbh_pkg::KIND_STATUS;
				res_status = adbh_pkg::WST_NO_LINK;
			end
			adbh_pkg::RES_ST_NOT_OPEN: begin
				res_kind   = adbh_pkg::KIND_STATUS;
				res_status = adbh_pkg::WST_NOT_OPEN;
			end
			default: begin
				res_kind = adbh_pkg::KIND_EVENT;
			end
		endcase
	end

	// Item and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= opcode;
			command_q <= command;
			a0_q      <= arg_first;
			a1_q      <= arg_second;
			magic_q   <= magic;
			dl_q      <= payload_len;
			hb_q      <= header_bytes;
			ws_q      <= slot;
		end
		if (cmd.emit) begin
			kind_q           <= res_kind;
			out_command_q    <= res_command;
			out_arg_first_q  <= res_arg_first;
			out_arg_second_q <= res_arg_second;
			out_length_q     <= res_length;
			out_magic_q      <= (res_kind == adbh_pkg::KIND_HDR) ? ~res_command : 32'd0;
			event_code_q     <= res_code;
			event_slot_q     <= (cmd.sel == adbh_pkg::RES_HDR_CNXN ||
				cmd.sel == adbh_pkg::RES_EVT_CONNECT) ? 3'd0 : 3'(cur_slot);
			write_status_q   <= res_status;
			last_q           <= cmd.last;
		end
	end

	// Table, flags, walk mask and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < adbh_pkg::SLOTS; i++) begin
				slot_status_q[i] <= adbh_pkg::SLOT_CLOSED;
				slot_remote_q[i] <= 32'd0;
			end
			present_q   <= 1'b0;
			link_q      <= 1'b0;
			sent_q      <= 1'b0;
			walk_mask_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				walk_mask_q <= (opcode == adbh_pkg::OP_TICK) ? tick_mask : det_mask;
			end
			if (cmd.clear_sent) begin
				sent_q <= 1'b0;
			end
			if (cmd.set_present) begin
				present_q <= 1'b1;
			end
			if (cmd.detach) begin
				present_q <= 1'b0;
				link_q    <= 1'b0;
			end
			if (cmd.okay_wr) begin
				slot_status_q[cur_slot] <= adbh_pkg::SLOT_OPEN;
			end
			if (cmd.emit) begin
				walk_mask_q[cur_slot] <= 1'b0;
				if (res_kind == adbh_pkg::KIND_HDR) begin
					sent_q <= 1'b1;
				end
				case (cmd.sel)
					adbh_pkg::RES_HDR_OPEN: begin
						slot_status_q[cur_slot] <= adbh_pkg::SLOT_OPENING;
					end
					adbh_pkg::RES_HDR_WRTE: begin
						slot_status_q[cur_slot] <= adbh_pkg::SLOT_WRITING;
					end
					adbh_pkg::RES_EVT_CONNECT: begin
						link_q <= 1'b1;
					end
					adbh_pkg::RES_EVT_OPEN: begin
						slot_status_q[cur_slot] <= adbh_pkg::SLOT_OPEN;
						slot_remote_q[cur_slot] <= a0_q;
					end
					adbh_pkg::RES_EVT_CLOSE: begin
						slot_status_q[cur_slot] <= cfg.reconnect_mask[cur_slot] ?
							adbh_pkg::SLOT_CLOSED : adbh_pkg::SLOT_UNUSED;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign out_command    = out_command_q;
	assign out_arg_first  = out_arg_first_q;
	assign out_arg_second = out_arg_second_q;
	assign out_length     = out_length_q;
	assign out_magic      = out_magic_q;
	assign event_code     = event_code_q;
	assign event_slot     = event_slot_q;
	assign write_status   = write_status_q;
	assign last           = last_q;

endmodule

FILE: rtl/adbh_ctrl.sv
module adbh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  adbh_pkg::adbh_sts_t  sts,
	output adbh_pkg::adbh_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_EMIT_A = 3'd2;
	localparam logic [2:0] S_EMIT_B = 3'd3;
	localparam logic [2:0] S_WALK   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [3:0] sel_a_q;
	logic [3:0] sel_a_d;
	logic [3:0] sel_b_q;
	logic [3:0] sel_b_d;
	logic       two_q;
	logic       two_d;

	assign in_ready = (state_q == S_IDLE);

	// Sequencing of one item: decode, then one result per cycle while the output register is free.
	always_comb begin
		state_d = state_q;
		sel_a_d = sel_a_q;
		sel_b_d = sel_b_q;
		two_d   = two_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				two_d   = 1'b0;
				case (sts.op)
					adbh_pkg::OP_TICK: begin
						if (sts.present) begin
							if (!sts.link) begin
								sel_a_d = adbh_pkg::RES_HDR_CNXN;
								state_d = S_EMIT_A;
							end else begin
								sel_a_d = adbh_pkg::RES_HDR_OPEN;
								state_d = S_WALK;
							end
						end
					end
					adbh_pkg::OP_HEADER: begin
						if (sts.present && sts.sent) begin
							cmd.clear_sent = 1'b1;
							if (sts.hdr_ok) begin
								if (sts.is_cnxn) begin
									sel_a_d = adbh_pkg::RES_EVT_CONNECT;
									state_d = S_EMIT_A;
								end else if (sts.id_ok) begin
									if (sts.is_okay) begin
										if (sts.cur_status == adbh_pkg::SLOT_OPENING) begin
											sel_a_d = adbh_pkg::RES_EVT_OPEN;
											state_d = S_EMIT_A;
										end else if (sts.cur_status == adbh_pkg::SLOT_WRITING) begin
											cmd.okay_wr = 1'b1;
										end
									end else if (sts.is_clse) begin
										sel_a_d = adbh_pkg::RES_EVT_CLOSE;
										state_d = S_EMIT_A;
									end else if (sts.is_wrte) begin
										state_d = S_EMIT_A;
										if (sts.dl_nz) begin
											sel_a_d = adbh_pkg::RES_EVT_DATA;
											sel_b_d = adbh_pkg::RES_HDR_OKAY;
											two_d   = 1'b1;
										end else begin
											sel_a_d = adbh_pkg::RES_HDR_OKAY;
										end
									end
								end
							end
						end
					end
					adbh_pkg::OP_ATTACH: begin
						cmd.set_present = 1'b1;
					end
					adbh_pkg::OP_DETACH: begin
						if (sts.present) begin
							cmd.detach = 1'b1;
							sel_a_d    = adbh_pkg::RES_EVT_CLOSE;
							state_d    = S_WALK;
						end
					end
					adbh_pkg::OP_WRITE: begin
						state_d = S_EMIT_A;
						if (!sts.present || !sts.link) begin
							sel_a_d = adbh_pkg::RES_ST_NO_LINK;
						end else if (!sts.ws_ok) begin
							sel_a_d = adbh_pkg::RES_ST_NOT_OPEN;
						end else begin
							sel_a_d = adbh_pkg::RES_HDR_WRTE;
							sel_b_d = adbh_pkg::RES_ST_ACCEPTED;
							two_d   = 1'b1;
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_EMIT_A: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = sel_a_q;
					cmd.last = !two_q;
					state_d  = two_q ? S_EMIT_B : S_IDLE;
				end
			end
			S_EMIT_B: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = sel_b_q;
					cmd.last = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_WALK: begin
				if (!sts.mask_any) begin
					state_d = S_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = sel_a_q;
					cmd.last = !sts.mask_more;
					if (!sts.mask_more) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sel_a_q <= adbh_pkg::RES_HDR_CNXN;
			sel_b_q <= adbh_pkg::RES_HDR_CNXN;
			two_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sel_a_q <= sel_a_d;
			sel_b_q <= sel_b_d;
			two_q   <= two_d;
		end
	end

	// A result is loaded only when the output register can take it.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result loaded into a full output register");

	// An empty walk ends the item at once.
	a_walk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK && !sts.mask_any) |=> (state_q == S_IDLE))
		else $error("walk did not end on an empty mask");

	// The load, emit, attach, detach and okay-write commands never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.emit, cmd.set_present, cmd.detach, cmd.okay_wr}))
		else $error("conflicting datapath commands");

endmodule

FILE: rtl/adb_host_connection_manager.sv
// An accepted request is decoded, then its first result is loaded into the output register.
// Throughput: a decode step, then one result per cycle while the output register drains; a
// new request is accepted only once the previous item is finished.
// A tick or detach walks one pending slot per cycle while output is free, highest slot first.
// Reset (arst_n low, asynchronous): all slots closed, no device, link down, config registers zero.
module adb_host_connection_manager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] command,
	input  logic [31:0] arg_first,
	input  logic [31:0] arg_second,
	input  logic [31:0] magic,
	input  logic [31:0] payload_len,
	input  logic [6:0]  header_bytes,
	input  logic [2:0]  slot,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [31:0] out_command,
	output logic [31:0] out_arg_first,
	output logic [31:0] out_arg_second,
	output logic [31:0] out_length,
	output logic [31:0] out_magic,
	output logic [2:0]  event_code,
	output logic [2:0]  event_slot,
	output logic [1:0]  write_status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [3:0]          slots_in_use_q;
	logic [7:0]          reconnect_mask_q;
	adbh_pkg::adbh_cfg_t cfg;
	adbh_pkg::adbh_cmd_t cmd;
	adbh_pkg::adbh_sts_t sts;

	assign pready = 1'b1;

	// Configuration registers, written in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_in_use_q   <= 4'd0;
			reconnect_mask_q <= 8'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == adbh_pkg::REG_SLOTS_IN_USE) begin
				slots_in_use_q <= pwdata[3:0];
			end else begin
				reconnect_mask_q <= pwdata[7:0];
			end
		end
	end

	// Read-back.
	assign prdata = (paddr[2] == adbh_pkg::REG_RECONNECT_MASK) ?
		{24'd0, reconnect_mask_q} : {28'd0, slots_in_use_q};

	assign cfg.slots_in_use   = slots_in_use_q;
	assign cfg.reconnect_mask = reconnect_mask_q;

	adbh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	adbh_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.opcode         (opcode),
		.command        (command),
		.arg_first      (arg_first),
		.arg_second     (arg_second),
		.magic          (magic),
		.payload_len    (payload_len),
		.header_bytes   (header_bytes),
		.slot           (slot),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.out_command    (out_command),
		.out_arg_first  (out_arg_first),
		.out_arg_second (out_arg_second),
		.out_length     (out_length),
		.out_magic      (out_magic),
		.event_code     (event_code),
		.event_slot     (event_slot),
		.write_status   (write_status),
		.last           (last)
	);

endmodule
